[rtl/fdc_pkg.sv]
// Shared types and constants for the floppy controller register model.
// No dependencies; imported by the top level.
package fdc_pkg;

  localparam int DRIVE_COUNT_DEF = 2;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int CYL_W       = 7;

  // Operations carried by the command field.
  typedef enum logic [1:0] {
    CMD_READ      = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_HEAD_SEL  = 2'd2,
    CMD_INSERT    = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_MOTOR = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CYL   = 1'b1;

  // Bit positions within the state lines.
  localparam int LN_CA2    = 2;
  localparam int LN_ENABLE = 4;
  localparam int LN_Q6     = 6;
  localparam int LN_Q7     = 7;

  // Drive control codes issued when CA2 is set.
  localparam logic [2:0] CTL_EJECT         = 3'd3;
  localparam logic [2:0] CTL_CLEAR_CHANGED = 3'd4;

  // Q7,Q6 register select codes.
  localparam logic [1:0] QSEL_DATA      = 2'b00;
  localparam logic [1:0] QSEL_STATUS    = 2'b01;
  localparam logic [1:0] QSEL_HANDSHAKE = 2'b10;
  localparam logic [1:0] QSEL_MODE      = 2'b11;

  localparam logic [7:0] HANDSHAKE_VAL = 8'h7f;
  localparam logic [7:0] MODE_MASK     = 8'h1f;
  localparam logic [7:0] ENABLE_FLAG   = 8'h20;
  localparam logic [7:0] STATUS_FLAG   = 8'h80;
  localparam logic [7:0] ALL_ONES      = 8'hff;

endpackage

[rtl/floppy_controller_register_model_top.sv]
// Floppy controller register model: state lines, mode byte, drive flags and read mux.
// Depends on fdc_pkg.

// One bus transaction is accepted per clock. Each item is decoded and applied to the state
// in the cycle it is accepted, and a read's byte appears in the result register on the next
// cycle. The input stalls only while the result register holds a byte that the receiver is
// stalling.
module floppy_controller_register_model_top #(
  parameter int DRIVE_COUNT = fdc_pkg::DRIVE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       command,
  input  logic [23:0]                      address,
  input  logic [7:0]                       write_data,
  input  logic                             drive_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       read_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fdc_pkg::*;

  logic                   motor_running;
  logic [CYL_W-1:0]       head_cylinder;
  logic [7:0]             control_lines;
  logic                   head_select_flag;
  logic [7:0]             mode_byte;
  logic [DRIVE_COUNT-1:0] disk_present;
  logic [DRIVE_COUNT-1:0] disk_changed;

  logic [7:0]             control_lines_next;
  logic                   head_select_flag_next;
  logic [7:0]             mode_byte_next;
  logic [DRIVE_COUNT-1:0] disk_present_next;
  logic [DRIVE_COUNT-1:0] disk_changed_next;

  cmd_t       cmd;
  logic       accept;
  logic       odd;
  logic       line_op;
  logic [2:0] line_sel;
  logic [7:0] line_mask;
  logic [7:0] lines_upd;
  logic [2:0] ctl_code;
  logic       present0_upd;
  logic       changed0_upd;
  logic [3:0] status_idx;
  logic       status_bit;
  logic [7:0] read_val;

  assign cmd       = cmd_t'(command);
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign odd       = address[0];
  assign line_op   = odd && (cmd == CMD_READ || cmd == CMD_WRITE);
  assign line_sel  = address[12:10];
  assign line_mask = 8'(1) << line_sel;
  assign ctl_code  = {head_select_flag, lines_upd[1:0]};

  always_comb begin
    lines_upd    = control_lines;
    present0_upd = disk_present[0];
    changed0_upd = disk_changed[0];
    if (line_op) begin
      if (address[9]) begin
        lines_upd = control_lines | line_mask;
      end else begin
        lines_upd = control_lines & ~line_mask;
      end
      // Setting CA2 strobes a drive control into drive 0.
      if (address[9] && line_sel == 3'(LN_CA2)) begin
        if (ctl_code == CTL_EJECT) begin
          present0_upd = 1'b0;
          changed0_upd = 1'b1;
        end else if (ctl_code == CTL_CLEAR_CHANGED) begin
          changed0_upd = 1'b0;
        end
      end
    end
  end

  assign status_idx = {head_select_flag, lines_upd[2:0]};

  always_comb begin
    unique case (status_idx)
      4'd2:    status_bit = !motor_running;
      4'd3:    status_bit = changed0_upd;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd12, 4'd14: status_bit = 1'b0;
      4'd8:    status_bit = !present0_upd;
      4'd10:   status_bit = (head_cylinder != '0);
      default: status_bit = 1'b1;
    endcase
  end

  always_comb begin
    read_val = '0;
    if (odd) begin
      unique case ({lines_upd[LN_Q7], lines_upd[LN_Q6]})
        QSEL_DATA:      read_val = lines_upd[LN_ENABLE] ? 8'h00 : ALL_ONES;
        QSEL_STATUS:    read_val = (mode_byte & MODE_MASK)
                                   | (lines_upd[LN_ENABLE] ? ENABLE_FLAG : 8'h00)
                                   | (status_bit ? STATUS_FLAG : 8'h00);
        QSEL_HANDSHAKE: read_val = HANDSHAKE_VAL | STATUS_FLAG;
        QSEL_MODE:      read_val = 8'h00;
        default:        read_val = 8'h00;
      endcase
    end
  end

  always_comb begin
    control_lines_next    = control_lines;
    head_select_flag_next = head_select_flag;
    mode_byte_next        = mode_byte;
    disk_present_next     = disk_present;
    disk_changed_next     = disk_changed;
    if (accept) begin
      unique case (cmd)
        CMD_READ, CMD_WRITE: begin
          control_lines_next   = lines_upd;
          disk_present_next[0] = present0_upd;
          disk_changed_next[0] = changed0_upd;
          if (cmd == CMD_WRITE && odd && lines_upd[LN_Q6] && lines_upd[LN_Q7]
              && !lines_upd[LN_ENABLE]) begin
            mode_byte_next = write_data;
          end
        end
        CMD_HEAD_SEL: head_select_flag_next = (write_data != 8'h00);
        CMD_INSERT: begin
          // A drive index beyond the fitted drives selects nothing.
          for (int i = 0; i < DRIVE_COUNT; i++) begin
            if (32'(drive_index) == i && !disk_present[i]) begin
              disk_present_next[i] = 1'b1;
              disk_changed_next[i] = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_running    <= 1'b0;
      head_cylinder    <= '0;
      control_lines    <= '0;
      head_select_flag <= 1'b0;
      mode_byte        <= '0;
      disk_present     <= '0;
      disk_changed     <= '0;
      out_valid        <= 1'b0;
    end else begin
      control_lines    <= control_lines_next;
      head_select_flag <= head_select_flag_next;
      mode_byte        <= mode_byte_next;
      disk_present     <= disk_present_next;
      disk_changed     <= disk_changed_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MOTOR: motor_running <= cfg_data[0];
          CFG_CYL:   head_cylinder <= cfg_data[CYL_W-1:0];
          default: ;
        endcase
      end
      if (accept && cmd == CMD_READ) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_READ) begin
      read_data <= read_val;
    end
  end

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_READ |=> out_valid)
    else $error("accepted read did not produce a result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !(accept && cmd == CMD_READ) |=> !out_valid)
    else $error("result appeared without an accepted read");

  a_even_read_zero: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_READ && !address[0] |=> read_data == 8'h00)
    else $error("even-address read returned non-zero data");

  a_mode_only_on_write: assert property (@(posedge clk) disable iff (rst)
    !(accept && cmd == CMD_WRITE) |=> $stable(mode_byte))
    else $error("mode byte changed without a write transaction");

endmodule

[sim/floppy_controller_register_model_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the floppy controller register model: directed and random bus
// transactions, register writes between phases, random idle gaps on the input and random stalls on the receiver side.
// Depends on fdc_pkg and floppy_controller_register_model_top.

import fdc_pkg::*;

// Mirror of the controller state; predicts the byte of every bus read and checks it.
class fdc_register_mirror;
  // Status mux entries that do not depend on the state, one bit per entry.
  localparam logic [15:0] FIXED_STATUS = 16'hAA03;
  localparam logic [3:0] ST_MOTOR_OFF   = 4'd2;
  localparam logic [3:0] ST_CHANGED     = 4'd3;
  localparam logic [3:0] ST_NO_DISK     = 4'd8;
  localparam logic [3:0] ST_CYL_NONZERO = 4'd10;

  logic                       motor_active;
  logic [CYL_W-1:0]           cylinder;
  logic [7:0]                 lines;
  logic                       head_one;
  logic [7:0]                 mode;
  logic [DRIVE_COUNT_DEF-1:0] present;
  logic [DRIVE_COUNT_DEF-1:0] changed;
  logic [7:0]                 expected_bytes[$];
  int unsigned                failures;

  function new();
    motor_active = 1'b0;
    cylinder = '0;
    lines    = '0;
    head_one = 1'b0;
    mode     = '0;
    present  = '0;
    changed  = '0;
    failures = 0;
  endfunction

  function void configure(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_MOTOR)
      motor_active = data[0];
    else if (idx == CFG_CYL)
      cylinder = data[CYL_W-1:0];
  endfunction

  function logic status_bit();
    logic [3:0] sel;
    sel = {head_one, lines[2:0]};
    case (sel)
      ST_MOTOR_OFF:   return !motor_active;
      ST_CHANGED:     return changed[0];
      ST_NO_DISK:     return !present[0];
      ST_CYL_NONZERO: return cylinder != '0;
      default:        return FIXED_STATUS[sel];
    endcase
  endfunction

  function void line_access(logic [3:0] code);
    logic [2:0] ctl;
    if (code[0]) begin
      lines[code[3:1]] = 1'b1;
      if (code[3:1] == LN_CA2) begin
        ctl = {head_one, lines[1:0]};
        if (ctl == CTL_EJECT) begin
          present[0] = 1'b0;
          changed[0] = 1'b1;
        end else if (ctl == CTL_CLEAR_CHANGED) begin
          changed[0] = 1'b0;
        end
      end
    end else begin
      lines[code[3:1]] = 1'b0;
    end
  endfunction

  function void note_item(cmd_t cmd, logic [23:0] addr, logic [7:0] wdata, logic drive);
    logic [7:0] val;
    val = '0;
    case (cmd)
      CMD_READ: begin
        if (addr[0]) begin
          line_access(addr[12:9]);
          case ({lines[LN_Q7], lines[LN_Q6]})
            QSEL_DATA:      val = lines[LN_ENABLE] ? 8'h00 : ALL_ONES;
            QSEL_STATUS: begin
              val = mode & MODE_MASK;
              if (lines[LN_ENABLE])
                val = val | ENABLE_FLAG;
              if (status_bit())
                val = val | STATUS_FLAG;
            end
            QSEL_HANDSHAKE: val = HANDSHAKE_VAL | STATUS_FLAG;
            default:        val = 8'h00;
          endcase
        end
        expected_bytes.push_back(val);
      end
      CMD_WRITE: begin
        if (addr[0]) begin
          line_access(addr[12:9]);
          if (lines[LN_Q6] && lines[LN_Q7] && !lines[LN_ENABLE])
            mode = wdata;
        end
      end
      CMD_HEAD_SEL: head_one = (wdata != 8'h00);
      default: begin
        if (drive < DRIVE_COUNT_DEF && !present[drive]) begin
          present[drive] = 1'b1;
          changed[drive] = 1'b1;
        end
      end
    endcase
  endfunction

  function void check_byte(logic [7:0] got);
    logic [7:0] want;
    if (expected_bytes.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("read_data %h arrived with no read outstanding", got);
      return;
    end
    want = expected_bytes.pop_front();
    if (got !== want) begin
      failures++;
      if (failures <= 10)
        $display("read_data mismatch: expected %h, actual %h", want, got);
    end
  endfunction
endclass

module floppy_controller_register_model_top_tb;
  localparam int LINE_CA0 = 0;
  localparam int LINE_CA1 = 1;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             command;
  logic [23:0]            address;
  logic [7:0]             write_data;
  logic                   drive_index;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             read_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fdc_register_mirror mirror;
  bit                 calm;
  int unsigned        hold_cycles;

  floppy_controller_register_model_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .address(address),
    .write_data(write_data),
    .drive_index(drive_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stall bursts, a long hold-off on request, none once the run is calm.
  initial begin
    int unsigned burst_left;
    bit          burst_stall;
    burst_left  = 0;
    burst_stall = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_stall = ($urandom_range(0, 2) == 0);
          burst_left  = $urandom_range(1, 7);
        end
        out_stall <= burst_stall;
        burst_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      mirror.check_byte(read_data);
  end

  // Address of an odd access that sets or clears one state line; other bits are random.
  function automatic logic [23:0] line_addr(int unsigned line, bit set_it);
    logic [23:0] a;
    a = 24'($urandom);
    a[12:9] = {line[2:0], set_it};
    a[0] = 1'b1;
    return a;
  endfunction

  task automatic send_item(cmd_t c, logic [23:0] a, logic [7:0] wd, logic drv);
    in_valid    <= 1'b1;
    command     <= c;
    address     <= a;
    write_data  <= wd;
    drive_index <= drv;
    do @(posedge clk); while (in_stall);
    mirror.note_item(c, a, wd, drv);
    @(negedge clk);
  endtask

  task automatic idle_input(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Holds the input off until every outstanding read has returned and the pipe is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (mirror.expected_bytes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Both registers are written back to back; called only while the block is idle.
  task automatic configure_block(logic [CFG_DATA_W-1:0] motor_data,
                                 logic [CFG_DATA_W-1:0] cyl_data);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MOTOR;
    cfg_data  <= motor_data;
    do @(posedge clk); while (!cfg_ready);
    mirror.configure(CFG_MOTOR, motor_data);
    @(negedge clk);
    cfg_index <= CFG_CYL;
    cfg_data  <= cyl_data;
    do @(posedge clk); while (!cfg_ready);
    mirror.configure(CFG_CYL, cyl_data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item();
    cmd_t        c;
    logic [23:0] a;
    logic [7:0]  wd;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      c = CMD_READ;
    else if (pick < 75)
      c = CMD_WRITE;
    else if (pick < 88)
      c = CMD_HEAD_SEL;
    else
      c = CMD_INSERT;
    a = 24'($urandom);
    // Most accesses are odd, since even reads and writes leave the state untouched.
    a[0] = ($urandom_range(0, 9) != 0);
    wd = 8'($urandom);
    if (c == CMD_HEAD_SEL && $urandom_range(0, 1) == 0)
      wd = 8'h00;
    if (!calm && $urandom_range(0, 3) == 0)
      idle_input($urandom_range(1, 7));
    send_item(c, a, wd, 1'($urandom));
  endtask

  initial begin
    mirror      = new();
    calm        = 1'b0;
    hold_cycles = 0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    command     = '0;
    address     = '0;
    write_data  = '0;
    drive_index = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Motor value carries spare high bits, which the block must mask off.
    configure_block(7'h7e, 7'h00);

    send_item(CMD_READ, 24'h000000, 8'h00, 1'b0);
    send_item(CMD_WRITE, 24'hfffffe, 8'hff, 1'b1);
    send_item(CMD_READ, 24'hfffffe, 8'h00, 1'b0);
    send_item(CMD_READ, 24'hffffff, 8'h00, 1'b0);
    send_item(CMD_READ, line_addr(LN_Q6, 1'b1), 8'h00, 1'b0);
    send_item(CMD_WRITE, line_addr(LN_ENABLE, 1'b0), 8'ha5, 1'b0);
    send_item(CMD_WRITE, line_addr(LN_Q7, 1'b0), 8'h5a, 1'b0);
    send_item(CMD_READ, line_addr(LINE_CA0, 1'b0), 8'h00, 1'b0);
    send_item(CMD_INSERT, 24'h000000, 8'h00, 1'b0);
    send_item(CMD_INSERT, 24'h000000, 8'h00, 1'b0);
    send_item(CMD_INSERT, 24'hffffff, 8'hff, 1'b1);
    send_item(CMD_READ, line_addr(LINE_CA0, 1'b1), 8'h00, 1'b0);
    send_item(CMD_READ, line_addr(LINE_CA1, 1'b1), 8'h00, 1'b0);
    // With head 0 and CA1..CA0 set, raising CA2 ejects the disk in drive 0.
    send_item(CMD_READ, line_addr(LN_CA2, 1'b1), 8'h00, 1'b0);
    send_item(CMD_READ, line_addr(LN_CA2, 1'b0), 8'h00, 1'b0);
    send_item(CMD_HEAD_SEL, 24'h000000, 8'h80, 1'b0);
    send_item(CMD_READ, line_addr(LINE_CA0, 1'b0), 8'h00, 1'b0);
    send_item(CMD_READ, line_addr(LINE_CA1, 1'b0), 8'h00, 1'b0);
    // Head 1 with CA1..CA0 clear: raising CA2 clears the disk-changed flag.
    send_item(CMD_READ, line_addr(LN_CA2, 1'b1), 8'h00, 1'b0);
    send_item(CMD_READ, line_addr(LN_CA2, 1'b0), 8'h00, 1'b0);
    send_item(CMD_HEAD_SEL, 24'h000000, 8'h00, 1'b0);
    send_item(CMD_READ, line_addr(LN_ENABLE, 1'b1), 8'h00, 1'b0);
    send_item(CMD_READ, line_addr(LN_Q6, 1'b0), 8'h00, 1'b0);
    send_item(CMD_READ, line_addr(LN_ENABLE, 1'b0), 8'h00, 1'b0);
    drain();

    configure_block(7'h01, 7'h7f);
    for (int i = 0; i < 350; i++) begin
      // The receiver holds off for a long stretch while transactions keep coming.
      if (i == 100)
        hold_cycles = 60;
      send_random_item();
    end
    drain();

    configure_block(7'h00, 7'h00);
    for (int i = 0; i < 350; i++) begin
      if (i == 175)
        drain();
      send_random_item();
    end
    drain();

    configure_block(7'h7f, 7'h01);
    for (int i = 0; i < 200; i++)
      send_random_item();
    drain();

    calm = 1'b1;
    configure_block(7'($urandom), 7'($urandom));
    for (int i = 0; i < 200; i++)
      send_random_item();
    drain();

    if (mirror.failures == 0 && mirror.expected_bytes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

[floppy_controller_register_model_top.f]
rtl/fdc_pkg.sv
rtl/floppy_controller_register_model_top.sv
sim/floppy_controller_register_model_top_tb.sv
